[rtl/nlrc_pkg.sv]
// ----------------------------------------------------------------------------
// nlrc_pkg: shared definitions for the node-local rank and CRC hash block
// Field widths, register indexes, map bounds and the CRC-32 fold function.
// ----------------------------------------------------------------------------
package nlrc_pkg;

   localparam int NODE_W  = 32;
   localparam int PROC_W  = 32;
   localparam int RANK_W  = 16;
   localparam int COUNT_W = 17;
   localparam int HASH_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Longest map the block is sized for.
   localparam int MAX_ENTRIES = 65536;
   // Rank wraps and the local count saturates at this bound.
   localparam int ENTRY_BOUND = (MAX_ENTRIES < 65536) ? MAX_ENTRIES : 65536;
   // Largest self index that can be reported.
   localparam int SELF_MAX    = 65535;

   localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB8_8320;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_NODE    = 2'd0,
      CSR_OWN_PROCESS = 2'd1,
      CSR_HASH_SEED   = 2'd2
   } csr_index_type;

   // Reflected CRC-32 over one 32-bit word, least significant byte first.
   // XOR-ing the whole word up front is equivalent to byte-wise feeding.
   function automatic logic [HASH_W-1:0] crc_fold_word(
      input logic [HASH_W-1:0] crc_in,
      input logic [31:0]       word
   );
      logic [HASH_W-1:0] crc;
      crc = crc_in ^ word;
      for (int k = 0; k < 32; k++) begin
         crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : '0);
      end
      return crc;
   endfunction

endpackage

[rtl/nlrc_if.sv]
// ----------------------------------------------------------------------------
// nlrc_if: channel interfaces for the node-local rank and CRC hash block
// Map entry request, per-entry response and register write channels.
// ----------------------------------------------------------------------------
interface nlrc_req_if;
   logic                        valid;
   logic                        ready;
   logic [nlrc_pkg::NODE_W-1:0] entry_node;
   logic [nlrc_pkg::PROC_W-1:0] entry_process;
   logic                        last_entry;

   modport source (output valid, output entry_node, output entry_process,
                   output last_entry, input ready);
   modport sink   (input valid, input entry_node, input entry_process,
                   input last_entry, output ready);
endinterface

interface nlrc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [nlrc_pkg::RANK_W-1:0]         entry_rank;
   logic                                is_local;
   logic [nlrc_pkg::COUNT_W-1:0]        local_count;
   logic signed [nlrc_pkg::COUNT_W-1:0] self_index;
   logic [nlrc_pkg::HASH_W-1:0]         running_hash;

   modport source (output valid, output entry_rank, output is_local,
                   output local_count, output self_index, output running_hash,
                   input ready);
   modport sink   (input valid, input entry_rank, input is_local,
                   input local_count, input self_index, input running_hash,
                   output ready);
endinterface

interface nlrc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [nlrc_pkg::CSR_IDX_W-1:0]  index;
   logic [nlrc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/node_local_rank_and_crc_hash_top.sv]
// ----------------------------------------------------------------------------
// node_local_rank_and_crc_hash_top: node-local rank finder with CRC-32 hash
// Streams a process map and reports rank, locality, self index and hash.
// ----------------------------------------------------------------------------
// Usage:
// A process map arrives on req_bus one entry per transaction (node id,
// process id, last-entry flag). Each entry yields exactly one transaction on
// rsp_bus carrying its rank in the map, whether it is local, the running
// local count, the local index of self (-1 until found) and the running
// reflected CRC-32 over all entry bytes so far, seeded from hash_seed.
// Registers are written over csr_bus, which is always ready; writes should
// happen only while no map entry is in flight. Indexes beyond the register
// list are dropped.
// An accepted request passes through one input register, then a single
// combinational pass into the response register. Throughput is one entry
// per cycle while rsp_bus is ready; the per-entry update of the counters
// and the 64-bit CRC fold closes within that single pass.
// When rsp_bus stalls, the response register holds and one more entry is
// taken into the input register; after that req_bus.ready drops.
// Synchronous reset clears the pipeline, the counters and the registers;
// the first entry after reset or after a last entry starts a new map.
// ----------------------------------------------------------------------------
module node_local_rank_and_crc_hash_top (
   input logic         clock,
   input logic         reset,
   nlrc_req_if.sink    req_bus,
   nlrc_rsp_if.source  rsp_bus,
   nlrc_csr_if.sink    csr_bus
);
   import nlrc_pkg::*;

   localparam logic [COUNT_W-1:0] BOUND_C    = COUNT_W'(ENTRY_BOUND);
   localparam logic [COUNT_W-1:0] SELF_MAX_C = COUNT_W'(SELF_MAX);

   // Configuration registers.
   logic [NODE_W-1:0] own_node_ff;
   logic [PROC_W-1:0] own_proc_ff;
   logic [HASH_W-1:0] hash_seed_ff;

   // Input register stage.
   logic              in_valid_ff, in_valid_in;
   logic [NODE_W-1:0] in_node_ff;
   logic [PROC_W-1:0] in_proc_ff;
   logic              in_last_ff;

   // Per-map state.
   logic [RANK_W-1:0]         rank_ff, rank_in;
   logic [COUNT_W-1:0]        local_cnt_ff, local_cnt_in;
   logic signed [COUNT_W-1:0] self_pos_ff, self_pos_in;
   logic [HASH_W-1:0]         hash_ff, hash_in;
   logic                      map_start_ff, map_start_in;

   // Response register stage.
   logic                      out_valid_ff, out_valid_in;
   logic [RANK_W-1:0]         out_rank_ff;
   logic                      out_local_ff;
   logic [COUNT_W-1:0]        out_count_ff;
   logic signed [COUNT_W-1:0] out_self_ff;
   logic [HASH_W-1:0]         out_hash_ff;

   // Datapath.
   logic                      advance;
   logic                      req_take;
   logic                      commit;
   logic                      entry_local;
   logic                      self_hit;
   logic [COUNT_W-1:0]        count_new;
   logic signed [COUNT_W-1:0] self_new;
   logic [HASH_W-1:0]         hash_base;
   logic [HASH_W-1:0]         hash_mid;
   logic [HASH_W-1:0]         hash_new;
   logic [COUNT_W-1:0]        rank_inc;

   // The response register can load when it is empty or being drained.
   assign advance  = !out_valid_ff || rsp_bus.ready;
   assign commit   = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // ---------------- configuration writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff  <= '0;
         own_proc_ff  <= '0;
         hash_seed_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_OWN_NODE:    own_node_ff  <= csr_bus.data;
            CSR_OWN_PROCESS: own_proc_ff  <= csr_bus.data;
            CSR_HASH_SEED:   hash_seed_ff <= csr_bus.data;
            default:         ;
         endcase
      end
   end

   // ---------------- input register ----------------
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_node_ff <= req_bus.entry_node;
         in_proc_ff <= req_bus.entry_process;
         in_last_ff <= req_bus.last_entry;
      end
   end

   // ---------------- single-pass entry update ----------------
   always_comb begin
      entry_local = (in_node_ff == own_node_ff);
      self_hit    = entry_local && (in_proc_ff == own_proc_ff);

      // Self index is the local count before this entry, clipped.
      if (self_hit) begin
         self_new = (local_cnt_ff > SELF_MAX_C) ? SELF_MAX_C : local_cnt_ff;
      end else begin
         self_new = self_pos_ff;
      end

      if (entry_local && (local_cnt_ff < BOUND_C)) begin
         count_new = local_cnt_ff + COUNT_W'(1);
      end else begin
         count_new = local_cnt_ff;
      end

      // The first entry of a map starts from the seed as it stands now.
      hash_base = map_start_ff ? hash_seed_ff : hash_ff;
      hash_mid  = crc_fold_word(hash_base, in_node_ff);
      hash_new  = crc_fold_word(hash_mid, in_proc_ff);

      rank_inc = {1'b0, rank_ff} + COUNT_W'(1);

      rank_in      = rank_ff;
      local_cnt_in = local_cnt_ff;
      self_pos_in  = self_pos_ff;
      hash_in      = hash_ff;
      map_start_in = map_start_ff;
      if (commit) begin
         if (in_last_ff) begin
            rank_in      = '0;
            local_cnt_in = '0;
            self_pos_in  = '1;
            hash_in      = hash_new;
            map_start_in = 1'b1;
         end else begin
            rank_in      = (rank_inc >= BOUND_C) ? '0 : rank_inc[RANK_W-1:0];
            local_cnt_in = count_new;
            self_pos_in  = self_new;
            hash_in      = hash_new;
            map_start_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= '0;
         local_cnt_ff <= '0;
         self_pos_ff  <= '1;
         hash_ff      <= '0;
         map_start_ff <= 1'b1;
      end else begin
         rank_ff      <= rank_in;
         local_cnt_ff <= local_cnt_in;
         self_pos_ff  <= self_pos_in;
         hash_ff      <= hash_in;
         map_start_ff <= map_start_in;
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_rank_ff  <= rank_ff;
         out_local_ff <= entry_local;
         out_count_ff <= count_new;
         out_self_ff  <= self_new;
         out_hash_ff  <= hash_new;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.entry_rank   = out_rank_ff;
   assign rsp_bus.is_local     = out_local_ff;
   assign rsp_bus.local_count  = out_count_ff;
   assign rsp_bus.self_index   = out_self_ff;
   assign rsp_bus.running_hash = out_hash_ff;

endmodule

[dv/node_local_rank_and_crc_hash_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// node_local_rank_and_crc_hash_top_tb: self-checking bench for the rank block
// Streams process maps through the block with random idling on both sides,
// predicts rank, locality, local count, self index and the running CRC-32
// for every entry, and compares each response field by field.
// ----------------------------------------------------------------------------
module node_local_rank_and_crc_hash_top_tb;
   import nlrc_pkg::*;

   // Index past the end of the register list; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // Cycles waited after the last response of each drain before going on.
   localparam int SETTLE_CYCLES = 8;
   // Length of the long response stall in the backpressure test.
   localparam int HOLD_CYCLES   = 60;
   // Random stimulus is split into phases, each with its own register values.
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_ITEMS   = 150;

   typedef struct {
      logic [RANK_W-1:0]         entry_rank;
      logic                      is_local;
      logic [COUNT_W-1:0]        local_count;
      logic signed [COUNT_W-1:0] self_index;
      logic [HASH_W-1:0]         running_hash;
   } entry_result_type;

   logic clock;
   logic reset;

   nlrc_req_if req_if ();
   nlrc_rsp_if rsp_if ();
   nlrc_csr_if csr_if ();

   node_local_rank_and_crc_hash_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // Shadow copy of the registers, updated when a write transaction completes.
   logic [NODE_W-1:0] shadow_own_node;
   logic [PROC_W-1:0] shadow_own_process;
   logic [HASH_W-1:0] shadow_hash_seed;

   // Shadow copy of the per-map state.
   logic [RANK_W-1:0]         map_rank;
   logic [COUNT_W-1:0]        map_local_count;
   logic signed [COUNT_W-1:0] map_self_index;
   logic [HASH_W-1:0]         map_crc;
   logic                      map_first_pending;

   // Responses that have been predicted but not yet seen on the response side.
   entry_result_type pending_entry_results[$];

   int mismatch_count;

   // Idling controls: the largest random gap of each side, and a request
   // counter that asks the response driver for one long stall.
   int req_max_gap;
   int rsp_max_gap;
   int rsp_hold_requests;

   // -------------------------------------------------------------------------
   // Clock, limit and reset
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A hung handshake would otherwise run forever. The bound covers every
   // item at the worst gaps on both sides plus the long stall, many times
   // over.
   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Reference behavior
   // -------------------------------------------------------------------------

   // Reflected CRC-32, fed one byte at a time, least significant byte first.
   function automatic logic [HASH_W-1:0] crc32_feed_word(
      input logic [HASH_W-1:0] crc_in,
      input logic [31:0]       word
   );
      logic [HASH_W-1:0] crc;
      crc = crc_in;
      for (int b = 0; b < 4; b++) begin
         crc = crc ^ {24'h0, word[8*b +: 8]};
         for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
               crc = (crc >> 1) ^ CRC_POLY;
            end else begin
               crc = crc >> 1;
            end
         end
      end
      return crc;
   endfunction

   function automatic void restart_map_state();
      map_rank          = '0;
      map_local_count   = '0;
      map_self_index    = '1;
      map_crc           = shadow_hash_seed;
      map_first_pending = 1'b1;
   endfunction

   // Works out the response of one accepted entry and queues it.
   function automatic void predict_map_entry(
      input logic [NODE_W-1:0] node,
      input logic [PROC_W-1:0] process,
      input logic              last
   );
      entry_result_type res;
      logic             hit;
      hit = (node == shadow_own_node);
      // The seed is taken when the first entry of a map arrives, so a seed
      // written in the middle of a map only affects the next one.
      if (map_first_pending) begin
         map_crc           = shadow_hash_seed;
         map_first_pending = 1'b0;
      end
      res.entry_rank = map_rank;
      if (hit) begin
         if (process == shadow_own_process) begin
            if (map_local_count > COUNT_W'(SELF_MAX)) begin
               map_self_index = COUNT_W'(SELF_MAX);
            end else begin
               map_self_index = map_local_count;
            end
         end
         if (map_local_count < COUNT_W'(ENTRY_BOUND)) begin
            map_local_count = map_local_count + COUNT_W'(1);
         end
      end
      map_crc = crc32_feed_word(map_crc, node);
      map_crc = crc32_feed_word(map_crc, process);
      res.is_local     = hit;
      res.local_count  = map_local_count;
      res.self_index   = map_self_index;
      res.running_hash = map_crc;
      pending_entry_results.push_back(res);
      // Rank wraps when the map grows past the entry bound.
      if (int'(map_rank) + 1 >= ENTRY_BOUND) begin
         map_rank = '0;
      end else begin
         map_rank = map_rank + RANK_W'(1);
      end
      if (last) begin
         restart_map_state();
      end
   endfunction

   function automatic void apply_register_write(
      input logic [CSR_IDX_W-1:0]  index,
      input logic [CSR_DATA_W-1:0] data
   );
      case (index)
         CSR_OWN_NODE: begin
            shadow_own_node = data;
         end
         CSR_OWN_PROCESS: begin
            shadow_own_process = data;
         end
         CSR_HASH_SEED: begin
            shadow_hash_seed = data;
         end
         default: begin
            // Indexes past the register list change nothing.
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Every response transaction is compared with the oldest prediction.
   initial begin : response_checker
      entry_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_entry_results.size() == 0) begin
               report_mismatch("response with no entry outstanding",
                               {16'h0, rsp_if.entry_rank}, '0);
            end else begin
               want = pending_entry_results.pop_front();
               if (rsp_if.entry_rank !== want.entry_rank) begin
                  report_mismatch("entry_rank", 32'(rsp_if.entry_rank),
                                  32'(want.entry_rank));
               end
               if (rsp_if.is_local !== want.is_local) begin
                  report_mismatch("is_local", 32'(rsp_if.is_local),
                                  32'(want.is_local));
               end
               if (rsp_if.local_count !== want.local_count) begin
                  report_mismatch("local_count", 32'(rsp_if.local_count),
                                  32'(want.local_count));
               end
               if (rsp_if.self_index !== want.self_index) begin
                  report_mismatch("self_index", 32'(rsp_if.self_index),
                                  32'(want.self_index));
               end
               if (rsp_if.running_hash !== want.running_hash) begin
                  report_mismatch("running_hash", rsp_if.running_hash, want.running_hash);
               end
            end
         end
      end
   end

   // Response-side ready. After each response transaction a new random gap
   // is drawn; a hold request from a test overrides it with a long stall.
   initial begin : response_ready_driver
      int  gap_left;
      int  hold_left;
      int  holds_served;
      bit  taken;
      gap_left     = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         taken = rsp_if.valid && rsp_if.ready;
         @(negedge clock);
         if (taken) begin
            gap_left = $urandom_range(0, rsp_max_gap);
         end
         if (rsp_hold_requests != holds_served) begin
            holds_served = rsp_hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offers one map entry after a random gap and waits for the transaction.
   // Valid stays high from one entry to the next when no gap is drawn.
   task automatic send_map_entry(input logic [NODE_W-1:0] node,
                                 input logic [PROC_W-1:0] process,
                                 input logic              last);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.entry_node    <= node;
      req_if.entry_process <= process;
      req_if.last_entry    <= last;
      do @(posedge clock); while (!req_if.ready);
      predict_map_entry(node, process, last);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0]  index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      apply_register_write(index, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Stops offering entries and waits until every response has arrived,
   // then lets the pipeline settle before registers are touched.
   task automatic wait_for_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_entry_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_register_value();
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Entry ids lean toward the own ids so that local and self hits are
   // frequent; near misses flip a single bit.
   function automatic logic [31:0] pick_entry_id(input logic [31:0] own_id,
                                                 input int        hit_weight);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < hit_weight) begin
         return own_id;
      end else if (roll == hit_weight) begin
         return own_id ^ (32'h1 << $urandom_range(0, 31));
      end else begin
         return $urandom();
      end
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // All registers read zero after reset: node 0 is local and process 0 is
   // self, and the all-ones ids are neither.
   task automatic test_reset_values();
      send_map_entry(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_map_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_map_entry(32'h0000_0000, 32'h0000_0005, 1'b1);
      wait_for_idle();
   endtask

   // All-ones registers; a second self match overwrites the first one.
   task automatic test_register_extremes();
      write_register(CSR_OWN_NODE, 32'hFFFF_FFFF);
      write_register(CSR_OWN_PROCESS, 32'hFFFF_FFFF);
      write_register(CSR_HASH_SEED, 32'hFFFF_FFFF);
      send_map_entry(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_map_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_map_entry(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_map_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      wait_for_idle();
   endtask

   // A write past the register list must leave every register unchanged.
   task automatic test_unused_register_index();
      write_register(CSR_UNUSED_INDEX, 32'h0000_0000);
      write_register(CSR_UNUSED_INDEX, $urandom());
      send_map_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_map_entry(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
      wait_for_idle();
   endtask

   // A seed written in the middle of a map must only take hold at the next
   // map start.
   task automatic test_seed_change_mid_map();
      write_register(CSR_OWN_NODE, 32'h0000_0042);
      write_register(CSR_OWN_PROCESS, 32'h0000_0007);
      write_register(CSR_HASH_SEED, 32'hA5A5_5A5A);
      send_map_entry(32'h0000_0042, 32'h0000_0001, 1'b0);
      send_map_entry(32'h0000_0043, 32'h0000_0007, 1'b0);
      wait_for_idle();
      write_register(CSR_HASH_SEED, 32'h0000_0000);
      send_map_entry(32'h0000_0042, 32'h0000_0007, 1'b0);
      send_map_entry(32'hC000_0042, 32'h0000_0007, 1'b1);
      send_map_entry(32'h0000_0042, 32'h8000_0007, 1'b0);
      send_map_entry(32'h0000_0042, 32'h0000_0007, 1'b1);
      wait_for_idle();
   endtask

   // Single-entry maps: every entry both starts and ends a map.
   task automatic test_single_entry_maps();
      send_map_entry(32'h0000_0042, 32'h0000_0007, 1'b1);
      send_map_entry(32'h0000_0042, 32'h0000_0007, 1'b1);
      send_map_entry(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
      wait_for_idle();
   endtask

   // The response side stalls for a long stretch while entries keep coming,
   // so the block fills and must stall its input.
   task automatic test_response_backpressure();
      req_max_gap = 0;
      rsp_hold_requests++;
      for (int i = 0; i < 24; i++) begin
         send_map_entry(pick_entry_id(shadow_own_node, 5),
                        pick_entry_id(shadow_own_process, 3), (i % 9) == 8);
      end
      wait_for_idle();
      req_max_gap = 7;
   endtask

   // Random maps in phases; each phase writes every register and picks how
   // much each side idles. Most maps are well formed; some set the last
   // flag at random.
   task automatic test_random_maps();
      int phase_sent;
      int map_len;
      bit broken;
      bit last;
      logic [NODE_W-1:0] node;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_register(CSR_OWN_NODE, pick_register_value());
         write_register(CSR_OWN_PROCESS, pick_register_value());
         write_register(CSR_HASH_SEED, pick_register_value());
         req_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 7;
         rsp_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 7;
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            map_len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
            broken  = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < map_len; i++) begin
               if (broken) begin
                  last = ($urandom_range(0, 3) == 0);
               end else begin
                  last = (i == map_len - 1);
               end
               node = pick_entry_id(shadow_own_node, 5);
               if (node == shadow_own_node) begin
                  send_map_entry(node, pick_entry_id(shadow_own_process, 3), last);
               end else begin
                  send_map_entry(node, $urandom(), last);
               end
            end
            phase_sent += map_len;
         end
         // Once per phase the sender waits for every response to come back.
         wait_for_idle();
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence of the run
   // -------------------------------------------------------------------------
   initial begin : test_sequence
      // Every input of the block starts at a known value, with reset held.
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.entry_node    = '0;
      req_if.entry_process = '0;
      req_if.last_entry    = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = CSR_OWN_NODE;
      csr_if.data          = '0;
      mismatch_count       = 0;
      req_max_gap          = 7;
      rsp_max_gap          = 7;
      rsp_hold_requests    = 0;
      shadow_own_node      = '0;
      shadow_own_process   = '0;
      shadow_hash_seed     = '0;
      restart_map_state();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_register_extremes();
      test_unused_register_index();
      test_seed_change_mid_map();
      test_single_entry_maps();
      test_response_backpressure();
      test_random_maps();

      // wait_for_idle has already drained every response and let the block
      // settle, so anything left over is an error.
      wait_for_idle();
      if (pending_entry_results.size() != 0) begin
         report_mismatch("responses never delivered", pending_entry_results.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
